// File: hw/rtl/brmr_pkg.sv
// Package: shared types and codes for the broadcast ring multi-reader core.
// Depends on nothing; used by every module under hw/rtl.
`default_nettype none
package brmr_pkg;

    typedef enum logic [1:0] {
        FUNC_POST     = 2'd0,
        FUNC_REGISTER = 2'd1,
        FUNC_FETCH    = 2'd2,
        FUNC_RELEASE  = 2'd3
    } func_t;

    typedef enum logic [1:0] {
        STAT_OK       = 2'd0,
        STAT_EMPTY    = 2'd1,
        STAT_NO_SLOT  = 2'd2,
        STAT_INACTIVE = 2'd3
    } status_t;

    localparam int unsigned ID_W   = 4;
    localparam int unsigned DATA_W = 64;
    localparam int unsigned LEN_W  = 4;
    localparam int unsigned DROP_W = 5;

    // One classified request as it travels from the front end to the back end
    typedef struct packed {
        func_t              func;
        logic [ID_W-1:0]    rid;
        logic [DATA_W-1:0]  payload;
        logic [LEN_W-1:0]   len;
    } cmd_t;

    typedef struct packed {
        status_t            status;
        logic [ID_W-1:0]    rid;
        logic [DATA_W-1:0]  payload;
        logic [LEN_W-1:0]   len;
        logic [DROP_W-1:0]  dropped;
    } res_t;

endpackage
`default_nettype wire

// File: hw/rtl/broadcast_ring_multi_reader_core.sv
// Broadcast ring with one writer and up to sixteen reader slots, drop-oldest on full.
// The back end takes one request a cycle while no result is held; a fetch that returns an
// entry blocks the next request while the registered read of the ring memory is done.
// Every result is registered in the back end and held while out_stall is high. The
// front end registers and cleans each request and a two-entry queue decouples it from
// the back end. A result held by out_stall stops the back end, while the queue and the
// front end go on taking up to three further requests before in_stall rises.
// Posts compare all reader heads in parallel. No clearing pass follows reset.
// Depends on brmr_pkg, brmr_front, brmr_queue and brmr_back.
`default_nettype none
module broadcast_ring_multi_reader_core
    import brmr_pkg::*;
#(
    parameter int unsigned RING_DEPTH  = 1024,
    parameter int unsigned MAX_READERS = 16,
    parameter int unsigned MSG_BYTES   = 8
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        func,
    input  wire logic [ID_W-1:0]   reader_id,
    input  wire logic [DATA_W-1:0] payload,
    input  wire logic [LEN_W-1:0]  length,
    output logic                   out_valid,
    input  wire logic              out_stall,
    output logic [1:0]             status,
    output logic [ID_W-1:0]        reader_id_res,
    output logic [DATA_W-1:0]      payload_res,
    output logic [LEN_W-1:0]       length_res,
    output logic [DROP_W-1:0]      dropped_count
);

    logic cmd_valid;
    logic cmd_ready;
    cmd_t cmd;
    logic q_valid;
    logic q_ready;
    cmd_t q_cmd;
    res_t res;

    brmr_front #(
        .MSG_BYTES (MSG_BYTES)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .func      (func),
        .reader_id (reader_id),
        .payload   (payload),
        .length    (length),
        .cmd_valid (cmd_valid),
        .cmd_ready (cmd_ready),
        .cmd       (cmd)
    );

    brmr_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (cmd_valid),
        .push_ready (cmd_ready),
        .push_cmd   (cmd),
        .pop_valid  (q_valid),
        .pop_ready  (q_ready),
        .pop_cmd    (q_cmd)
    );

    brmr_back #(
        .RING_DEPTH  (RING_DEPTH),
        .MAX_READERS (MAX_READERS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd_valid (q_valid),
        .cmd_ready (q_ready),
        .cmd       (q_cmd),
        .res_valid (out_valid),
        .res_stall (out_stall),
        .res       (res)
    );

    assign status        = res.status;
    assign reader_id_res = res.rid;
    assign payload_res   = res.payload;
    assign length_res    = res.len;
    assign dropped_count = res.dropped;

endmodule
`default_nettype wire

// File: hw/rtl/brmr_front.sv
// Front end: accepts requests, saturates the length and masks the payload.
// Depends on brmr_pkg.
`default_nettype none
module brmr_front
    import brmr_pkg::*;
#(
    parameter int unsigned MSG_BYTES = 8
)(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_stall,
    input  wire logic [1:0]        func,
    input  wire logic [ID_W-1:0]   reader_id,
    input  wire logic [DATA_W-1:0] payload,
    input  wire logic [LEN_W-1:0]  length,
    output logic                   cmd_valid,
    input  wire logic              cmd_ready,
    output cmd_t                   cmd
);

    localparam logic [LEN_W-1:0] MAX_LEN = LEN_W'(MSG_BYTES);

    logic              valid_reg;
    cmd_t              cmd_reg;
    cmd_t              cmd_next;
    logic [LEN_W-1:0]  len_sat;

    assign in_stall  = valid_reg && !cmd_ready;
    assign cmd_valid = valid_reg;
    assign cmd       = cmd_reg;

    always_comb
    begin
        len_sat = (length > MAX_LEN) ? MAX_LEN : length;
        cmd_next.func = func_t'(func);
        cmd_next.rid  = reader_id;
        cmd_next.len  = len_sat;
        for (int b = 0; b < DATA_W / 8; b++)
        begin
            // drop bytes at or beyond the length
            cmd_next.payload[b*8 +: 8] = (LEN_W'(b) < len_sat) ? payload[b*8 +: 8] : 8'h00;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else if (!in_stall)
        begin
            valid_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_valid && !in_stall)
        begin
            cmd_reg <= cmd_next;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/brmr_queue.sv
// Two-entry request queue between the front end and the back end.
// Depends on brmr_pkg.
`default_nettype none
module brmr_queue
    import brmr_pkg::*;
(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic push_valid,
    output logic      push_ready,
    input  cmd_t      push_cmd,
    output logic      pop_valid,
    input  wire logic pop_ready,
    output cmd_t      pop_cmd
);

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic       push;
    logic       pop;

    assign push_ready = (count_reg != 2'd2);
    assign pop_valid  = (count_reg != 2'd0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
            begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop)
            begin
                rd_ptr_reg <= !rd_ptr_reg;
            end
            if (push && !pop)
            begin
                count_reg <= count_reg + 2'd1;
            end
            else if (pop && !push)
            begin
                count_reg <= count_reg - 2'd1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule
`default_nettype wire

// File: hw/rtl/brmr_back.sv
// Back end: ring memory, write pointer, reader heads and the result register.
// Depends on brmr_pkg.
`default_nettype none
module brmr_back
    import brmr_pkg::*;
#(
    parameter int unsigned RING_DEPTH = 1024,
    parameter int unsigned MAX_READERS = 16
)(
    input  wire logic clk,
    input  wire logic rst_n,
    input  wire logic cmd_valid,
    output logic      cmd_ready,
    input  cmd_t      cmd,
    output logic      res_valid,
    input  wire logic res_stall,
    output res_t      res
);

    localparam int unsigned PW         = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int unsigned SLOT_LIMIT = (MAX_READERS < 16) ? MAX_READERS : 16;
    localparam int unsigned SW         = (SLOT_LIMIT > 1) ? $clog2(SLOT_LIMIT) : 1;
    localparam logic [PW-1:0] LAST_IDX = PW'(RING_DEPTH - 1);

    typedef enum logic [1:0] {
        ST_RUN  = 2'b01,
        ST_READ = 2'b10
    } state_t;

    function automatic logic [PW-1:0] next_index(input logic [PW-1:0] i);
        return (i == LAST_IDX) ? '0 : i + PW'(1);
    endfunction

    logic [DATA_W-1:0] ring_payload [RING_DEPTH];
    logic [LEN_W-1:0]  ring_length  [RING_DEPTH];
    logic [DATA_W-1:0] rd_payload_reg;
    logic [LEN_W-1:0]  rd_length_reg;

    state_t            state_reg, state_next;
    logic [PW-1:0]     wp_reg;
    logic [PW-1:0]     head_reg   [SLOT_LIMIT];
    logic [SLOT_LIMIT-1:0] active_reg;
    logic              res_valid_reg;
    res_t              res_reg;
    res_t              res_next;

    logic              out_free;
    logic              take;
    logic [PW-1:0]     after;
    logic [SLOT_LIMIT-1:0] drop_hit;
    logic [DROP_W-1:0] drop_cnt;
    logic              free_found;
    logic [SW-1:0]     free_idx;
    logic              rid_ok;
    logic [SW-1:0]     rid_idx;
    logic [PW-1:0]     rid_head;
    logic              fetch_ok;
    logic              load_res;

    assign out_free  = !res_valid_reg || !res_stall;
    assign cmd_ready = (state_reg == ST_RUN) && out_free;
    assign take      = cmd_valid && cmd_ready;
    assign res_valid = res_valid_reg;
    assign res       = res_reg;

    assign after    = next_index(wp_reg);
    assign rid_idx  = cmd.rid[SW-1:0];
    assign rid_ok   = ({1'b0, cmd.rid} < (ID_W + 1)'(SLOT_LIMIT)) && active_reg[rid_idx];
    assign rid_head = head_reg[rid_idx];
    assign fetch_ok = (cmd.func == FUNC_FETCH) && rid_ok && (rid_head != wp_reg);

    always_comb
    begin
        drop_cnt = '0;
        for (int i = 0; i < SLOT_LIMIT; i++)
        begin
            drop_hit[i] = active_reg[i] && (head_reg[i] == after);
            drop_cnt    = drop_cnt + DROP_W'(drop_hit[i]);
        end
    end

    always_comb
    begin
        free_found = 1'b0;
        free_idx   = '0;
        for (int i = SLOT_LIMIT - 1; i >= 0; i--)
        begin
            if (!active_reg[i])
            begin
                free_found = 1'b1;
                free_idx   = SW'(i);
            end
        end
    end

    always_comb
    begin
        res_next         = '0;
        res_next.status  = STAT_OK;
        load_res         = 1'b0;
        state_next       = state_reg;
        unique case (state_reg)
            ST_RUN:
            begin
                if (take)
                begin
                    load_res = 1'b1;
                    unique case (cmd.func)
                        FUNC_POST:
                        begin
                            res_next.dropped = drop_cnt;
                        end
                        FUNC_REGISTER:
                        begin
                            if (free_found)
                            begin
                                res_next.rid = ID_W'(free_idx);
                            end
                            else
                            begin
                                res_next.status = STAT_NO_SLOT;
                            end
                        end
                        FUNC_FETCH, FUNC_RELEASE:
                        begin
                            res_next.rid = cmd.rid;
                            if (!rid_ok)
                            begin
                                res_next.status = STAT_INACTIVE;
                            end
                            else if (cmd.func == FUNC_FETCH && !fetch_ok)
                            begin
                                res_next.status = STAT_EMPTY;
                            end
                            else if (fetch_ok)
                            begin
                                // wait for the ring read
                                load_res   = 1'b0;
                                state_next = ST_READ;
                            end
                        end
                        default:
                        begin
                            res_next.status = STAT_OK;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                load_res         = 1'b1;
                res_next.rid     = res_reg.rid;
                res_next.payload = rd_payload_reg;
                res_next.len     = rd_length_reg;
                state_next       = ST_RUN;
            end
            default:
            begin
                state_next = ST_RUN;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_RUN;
            wp_reg        <= '0;
            active_reg    <= '0;
            res_valid_reg <= 1'b0;
            for (int i = 0; i < SLOT_LIMIT; i++)
            begin
                head_reg[i] <= '0;
            end
        end
        else
        begin
            state_reg <= state_next;
            if (load_res)
            begin
                res_valid_reg <= 1'b1;
            end
            else if (!res_stall)
            begin
                res_valid_reg <= 1'b0;
            end
            if (take)
            begin
                unique case (cmd.func)
                    FUNC_POST:
                    begin
                        for (int i = 0; i < SLOT_LIMIT; i++)
                        begin
                            if (drop_hit[i])
                            begin
                                head_reg[i] <= next_index(head_reg[i]);
                            end
                        end
                        wp_reg <= after;
                    end
                    FUNC_REGISTER:
                    begin
                        if (free_found)
                        begin
                            active_reg[free_idx] <= 1'b1;
                            head_reg[free_idx]   <= wp_reg;
                        end
                    end
                    FUNC_FETCH:
                    begin
                        if (fetch_ok)
                        begin
                            head_reg[rid_idx] <= next_index(rid_head);
                        end
                    end
                    FUNC_RELEASE:
                    begin
                        if (rid_ok)
                        begin
                            active_reg[rid_idx] <= 1'b0;
                        end
                    end
                    default:
                    begin
                        wp_reg <= wp_reg;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (load_res)
        begin
            res_reg <= res_next;
        end
        else if (take && fetch_ok)
        begin
            // hold the slot number for the read cycle
            res_reg.rid <= cmd.rid;
        end
    end

    // ring memory: one write port for posts, one registered read for fetches
    always_ff @(posedge clk)
    begin
        if (take && cmd.func == FUNC_POST)
        begin
            ring_payload[wp_reg] <= cmd.payload;
            ring_length[wp_reg]  <= cmd.len;
        end
        rd_payload_reg <= ring_payload[rid_head];
        rd_length_reg  <= ring_length[rid_head];
    end

endmodule
`default_nettype wire
